// File: sv/sha_pkg.sv
package sha_pkg;

  localparam int unsigned BlkBytes  = 64;
  localparam int unsigned PadLimit  = 56;
  localparam logic [7:0]  PadByte   = 8'h80;

  // request kinds carried on tuser
  localparam logic KindAppend = 1'b0;
  localparam logic KindFinish = 1'b1;

  // front -> back request: one 64-byte block plus a flag marking the last one
  typedef struct packed {
    logic [511:0] blk;
    logic         last;
  } sha_req_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: sv/sha_front.sv
// Gathers bytes, pads on finish, pushes whole blocks to the queue.
module sha_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [7:0]        in_byte,
  output logic              q_valid,
  input  logic              q_ready,
  output sha_pkg::sha_req_t q_req
);
  import sha_pkg::*;

  typedef enum logic [1:0] {S_FILL, S_PAD, S_PUSH} st_t;

  st_t          st_r;
  logic [511:0] acc_r;     // byte shift register, oldest byte on top
  logic [5:0]   fill_r;
  logic [60:0]  len_r;
  logic [63:0]  bits_r;
  logic         len_ok_r;  // length field goes into the current block
  logic         pad_r;     // finish in progress
  logic         last_r;
  logic [511:0] blk_r;
  logic [7:0]   pad_byte;

  // zeros up to the length field, then the bit length, high byte first
  assign pad_byte = (len_ok_r && fill_r >= 6'(PadLimit)) ? bits_r[63:56] : 8'h00;

  assign in_ready = (st_r == S_FILL);
  assign q_valid  = (st_r == S_PUSH);
  assign q_req    = '{blk: blk_r, last: last_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_FILL;
      fill_r   <= '0;
      len_r    <= '0;
      len_ok_r <= 1'b0;
      pad_r    <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      case (st_r)
        S_FILL: begin
          if (in_valid) begin
            if (in_kind == KindAppend) begin
              acc_r  <= {acc_r[503:0], in_byte};
              fill_r <= fill_r + 6'd1;
              len_r  <= len_r + 61'd1;
              if (fill_r == 6'(BlkBytes - 1)) begin
                blk_r  <= {acc_r[503:0], in_byte};
                last_r <= 1'b0;
                st_r   <= S_PUSH;
              end
            end else begin
              acc_r    <= {acc_r[503:0], PadByte};
              fill_r   <= fill_r + 6'd1;
              bits_r   <= {len_r, 3'b000};
              len_r    <= '0;
              len_ok_r <= (fill_r < 6'(PadLimit));
              pad_r    <= 1'b1;
              last_r   <= 1'b0;
              if (fill_r == 6'(BlkBytes - 1)) begin
                blk_r <= {acc_r[503:0], PadByte};
                st_r  <= S_PUSH;
              end else begin
                st_r  <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          acc_r  <= {acc_r[503:0], pad_byte};
          fill_r <= fill_r + 6'd1;
          if (len_ok_r && fill_r >= 6'(PadLimit)) bits_r <= {bits_r[55:0], 8'h00};
          if (fill_r == 6'(BlkBytes - 1)) begin
            blk_r  <= {acc_r[503:0], pad_byte};
            last_r <= len_ok_r;
            st_r   <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (q_ready) begin
            len_ok_r <= 1'b1;
            if (pad_r && !last_r) begin
              st_r <= S_PAD;
            end else begin
              pad_r <= 1'b0;
              st_r  <= S_FILL;
            end
          end
        end
        default: st_r <= S_FILL;
      endcase
    end
  end
endmodule

// File: sv/sha_queue.sv
// Two-entry block queue between front and back.
module sha_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  sha_pkg::sha_req_t wr_req,
  output logic              rd_valid,
  input  logic              rd_ready,
  output sha_pkg::sha_req_t rd_req
);
  import sha_pkg::*;

  sha_req_t   ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_req   = ent_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) ent_r[wp_r] <= wr_req;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
  end
endmodule

// File: sv/sha_core.sv
// One round per cycle compression; emits digest after a last block.
module sha_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  sha_pkg::sha_req_t q_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [255:0]      out_dig
);
  import sha_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_ADD, C_OUT} st_t;

  st_t          st_r;
  logic [255:0] h_r;
  logic [31:0]  v_r [8];
  logic [31:0]  w_r [16];
  logic [5:0]   rnd_r;
  logic         last_r;
  logic [255:0] dig_r;
  logic [31:0]  t1, t2, wn, s0, s1;

  always_comb begin
    t1 = v_r[7] + (ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25)) +
         ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + RoundK[rnd_r] + w_r[0];
    t2 = (ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22)) +
         ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    s0 = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
  end

  assign q_ready   = (st_r == C_IDLE);
  assign out_valid = (st_r == C_OUT);
  assign out_dig   = dig_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= C_IDLE;
      h_r   <= InitH;
      rnd_r <= '0;
    end else begin
      case (st_r)
        C_IDLE: begin
          if (q_valid) begin
            for (int i = 0; i < 16; i++) w_r[i] <= q_req.blk[511-32*i -: 32];
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[255-32*i -: 32];
            last_r <= q_req.last;
            rnd_r  <= '0;
            st_r   <= C_RUN;
          end
        end
        C_RUN: begin
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wn;
          rnd_r   <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) st_r <= C_ADD;
        end
        C_ADD: begin
          if (last_r) begin
            for (int i = 0; i < 8; i++)
              dig_r[255-32*i -: 32] <= h_r[255-32*i -: 32] + v_r[i];
            h_r  <= InitH;
            st_r <= C_OUT;
          end else begin
            for (int i = 0; i < 8; i++)
              h_r[255-32*i -: 32] <= h_r[255-32*i -: 32] + v_r[i];
            st_r <= C_IDLE;
          end
        end
        C_OUT: if (out_ready) st_r <= C_IDLE;
        default: st_r <= C_IDLE;
      endcase
    end
  end
endmodule

// File: sv/sha256_stream_hasher.sv
// Channel | dir | tdata                      | tuser
// in_     | in  | [7:0] data_byte            | [0] kind (0 append, 1 finish)
// out_    | out | [255:0] digest words 0..7  | -
//
// Append: the 64th byte of a block sends the block to the queue; in_ stalls until it is taken.
// Finish: pads the block to its end (0x80, zeros, length) and queues it; when 0x80
// lands past byte 55, a further block of zeros and the length follows.
// The round engine handles each block as load, 64 rounds, add.
// A two-entry block queue lets gathering overlap compression; a full queue stalls in_.
// Reset (rst_n low, synchronous) restores initial hash values and empties the queue.
// A stalled out_ holds the digest; the engine then stops taking blocks.
module sha256_stream_hasher (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata   // word0 [31:0] .. word7 [255:224]
);
  import sha_pkg::*;

  logic     f_valid, f_ready, b_valid, b_ready;
  sha_req_t f_req, b_req;
  logic [255:0] dig;

  sha_front u_front (.clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .in_kind(in_tuser), .in_byte(in_tdata), .q_valid(f_valid), .q_ready(f_ready),
    .q_req(f_req));

  sha_queue u_queue (.clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_req(f_req), .rd_valid(b_valid), .rd_ready(b_ready), .rd_req(b_req));

  sha_core u_core (.clk, .rst_n, .q_valid(b_valid), .q_ready(b_ready), .q_req(b_req),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_dig(dig));

  // digest word j lands at bits 32j+31:32j
  always_comb begin
    for (int j = 0; j < 8; j++) out_tdata[32*j +: 32] = dig[255-32*j -: 32];
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("digest dropped while stalled");
  a_noblk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !b_ready)
    else $error("engine took a block while digest pending");
endmodule

// File: sim/sha256_stream_hasher_tb.sv
`timescale 1ns / 100ps

module sha256_stream_hasher_tb;

  localparam logic KIND_APPEND = sha_pkg::KindAppend;
  localparam logic KIND_FINISH = sha_pkg::KindFinish;
  localparam int   IDLE_LIMIT  = 20000;
  localparam int   PHASE_ITEMS = 385;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } hash_req_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;   // [7:0] data_byte
  logic         in_tuser;   // [0] kind
  logic         out_tvalid;
  logic         out_tready;
  logic [255:0] out_tdata;  // word0 [31:0] .. word7 [255:224]

  sha256_stream_hasher dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  // requests waiting for the driver, digests waiting for the monitor
  hash_req_t     req_q[$];
  logic [255:0]  digest_q[$];

  // predictor state
  logic [31:0] hash_h[8];
  logic [7:0]  blk_buf[64];
  logic [5:0]  blk_fill;
  logic [60:0] msg_len;

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_send;
  int  fail_cnt = 0;
  int  idle_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_init();
    hash_h = '{sha_pkg::InitH[255:224], sha_pkg::InitH[223:192], sha_pkg::InitH[191:160],
               sha_pkg::InitH[159:128], sha_pkg::InitH[127:96], sha_pkg::InitH[95:64],
               sha_pkg::InitH[63:32], sha_pkg::InitH[31:0]};
    blk_fill = '0;
    msg_len  = '0;
  endtask

  task automatic compress();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    v = hash_h;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endtask

  // advance the predictor by one request
  task automatic hash_update(hash_req_t r);
    logic [63:0]  bit_len;
    logic [255:0] dig;
    int           p;
    if (r.kind == KIND_APPEND) begin
      blk_buf[blk_fill] = r.data_byte;
      msg_len  = msg_len + 61'd1;
      blk_fill = blk_fill + 6'd1;
      if (blk_fill == 6'd0) compress();
    end else begin
      bit_len = {msg_len, 3'b000};
      p = int'(blk_fill);
      blk_buf[p] = sha_pkg::PadByte;
      p = p + 1;
      if (p > int'(sha_pkg::PadLimit)) begin
        for (int i = p; i < 64; i++) blk_buf[i] = 8'h00;
        compress();
        p = 0;
      end
      for (int i = p; i < int'(sha_pkg::PadLimit); i++) blk_buf[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk_buf[56+i] = bit_len[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) dig[32*i +: 32] = hash_h[i];
      digest_q.push_back(dig);
      hash_init();
    end
  endtask

  function automatic hash_req_t mk(logic kind, logic [7:0] b);
    hash_req_t r;
    r.kind = kind;
    r.data_byte = b;
    return r;
  endfunction

  task automatic add_msg(int len, int mode);
    for (int i = 0; i < len; i++)
      case (mode)
        0: req_q.push_back(mk(KIND_APPEND, 8'($urandom)));
        1: req_q.push_back(mk(KIND_APPEND, 8'hff));
        default: req_q.push_back(mk(KIND_APPEND, 8'h00));
      endcase
    // finish with random junk in data_byte: must be ignored
    req_q.push_back(mk(KIND_FINISH, 8'($urandom)));
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= KIND_APPEND;
    end else if (!in_tvalid || in_tready) begin
      if (req_q.size() != 0 && !hold_send && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= req_q[0].data_byte;
        in_tuser  <= req_q[0].kind;
        hash_update(req_q.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    logic [255:0] exp_d;
    if (!rst_n) begin
      out_tready  <= 1'b0;
      idle_cycles <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest %h", out_tdata);
          fail_cnt++;
        end else begin
          exp_d = digest_q.pop_front();
          for (int i = 0; i < 8; i++)
            if (out_tdata[32*i +: 32] !== exp_d[32*i +: 32]) begin
              $error("digest_word_%0d expected %h actual %h", i,
                     exp_d[32*i +: 32], out_tdata[32*i +: 32]);
              fail_cnt++;
            end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("sha256_stream_hasher_tb NOT OK");
        $finish;
      end
    end
  end

  // a request is in flight if the driver still holds one not yet taken
  function automatic bit all_drained();
    return req_q.size() == 0 && !(in_tvalid && !in_tready) && digest_q.size() == 0;
  endfunction

  initial begin
    int n;
    int len;
    rst_n = 1'b0;
    hold_send = 1'b0;
    send_idle_pct = 29; recv_idle_pct = 72;
    hash_init();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty message, pad boundaries, all-ones and all-zero bytes
    add_msg(0, 0);
    add_msg(3, 1);
    add_msg(55, 2);
    add_msg(56, 0);
    add_msg(63, 1);
    add_msg(64, 0);
    add_msg(119, 2);
    add_msg(120, 0);
    req_q.push_back(mk(KIND_FINISH, 8'h00));
    req_q.push_back(mk(KIND_FINISH, 8'hff));

    // pause: wait until every digest is out, then hold the sender before the random phases
    while (!all_drained()) @(posedge clk);
    hold_send = 1'b1;
    repeat (200) @(posedge clk);
    hold_send = 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 29; recv_idle_pct = 72; end
        1: begin send_idle_pct = 72; recv_idle_pct = 29; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      n = 0;
      while (n < PHASE_ITEMS) begin
        // short messages most often, others around block edges, a few long ones
        case ($urandom_range(9))
          0, 1, 2, 3: len = $urandom_range(0, 20);
          4, 5, 6:    len = $urandom_range(50, 70);
          7, 8:       len = $urandom_range(110, 130);
          default:    len = $urandom_range(150, 200);
        endcase
        if (len > PHASE_ITEMS - n) len = PHASE_ITEMS - n;
        add_msg(len, 0);
        n += len + 1;
        while (req_q.size() >= 64) @(posedge clk);
      end
      while (req_q.size() != 0) @(posedge clk);
    end

    while (!all_drained()) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_cnt == 0 && digest_q.size() == 0) begin
      $display("sha256_stream_hasher_tb OK");
    end else begin
      $display("sha256_stream_hasher_tb NOT OK");
    end
    $finish;
  end

endmodule
